FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_SAME(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: rtl/tdpc_pkg.sv
package tdpc_pkg;

    localparam int FUNC_W   = 2;
    localparam int SYMBOL_W = 7;
    localparam int X_W      = 6;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 2;
    localparam int TOTAL_W  = 23;
    localparam int HASH_W   = 30;
    localparam int MUL_W    = X_W;

    localparam logic [FUNC_W-1:0] FUNC_PATTERN = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_GRID    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS    = 2'd2;

    localparam logic [HASH_W-1:0]   MOD_A     = 30'd1000000007;
    localparam logic [HASH_W-1:0]   MOD_B     = 30'd1000000009;
    localparam logic [MUL_W-1:0]    BASE      = 6'd26;
    localparam logic [SYMBOL_W-1:0] SYM_BASE  = 7'd65;
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX = 23'd4194304;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] mul;
    } mac_req_t;

    // one double-and-add step, result stays below m
    function automatic logic [HASH_W-1:0] mod_dbl_add(
        input logic [HASH_W-1:0] r,
        input logic [HASH_W-1:0] a,
        input logic              add,
        input logic [HASH_W-1:0] m
    );
        logic [HASH_W:0] d;
        logic [HASH_W:0] s;
        d = {r, 1'b0};
        if (d >= {1'b0, m})
        begin
            d = d - {1'b0, m};
        end
        s = d + (add ? {1'b0, a} : '0);
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[HASH_W-1:0];
    endfunction

    function automatic logic [HASH_W-1:0] mod_add(
        input logic [HASH_W-1:0] a,
        input logic [HASH_W-1:0] b,
        input logic [HASH_W-1:0] m
    );
        logic [HASH_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[HASH_W-1:0];
    endfunction

    function automatic logic [HASH_W-1:0] mod_sub(
        input logic [HASH_W-1:0] a,
        input logic [HASH_W-1:0] b,
        input logic [HASH_W-1:0] m
    );
        logic [HASH_W:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d[HASH_W])
        begin
            d = d + {1'b0, m};
        end
        return d[HASH_W-1:0];
    endfunction

endpackage

FILE: rtl/tdpc_ram.sv
module tdpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data until the next read
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/tdpc_mac.sv
module tdpc_mac (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tdpc_pkg::mac_req_t              req,
    input  logic [tdpc_pkg::HASH_W-1:0]     a_a,
    input  logic [tdpc_pkg::HASH_W-1:0]     a_b,
    input  logic [tdpc_pkg::HASH_W-1:0]     c_a,
    input  logic [tdpc_pkg::HASH_W-1:0]     c_b,
    output logic                            done,
    output logic [tdpc_pkg::HASH_W-1:0]     r_a,
    output logic [tdpc_pkg::HASH_W-1:0]     r_b
);
    import tdpc_pkg::*;

    localparam int STEP_W = $clog2(MUL_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [MUL_W-1:0]  mul_reg;
    logic [HASH_W-1:0] a_a_reg;
    logic [HASH_W-1:0] a_b_reg;
    logic [HASH_W-1:0] c_a_reg;
    logic [HASH_W-1:0] c_b_reg;
    logic [HASH_W-1:0] r_a_reg;
    logic [HASH_W-1:0] r_b_reg;

    // (a * mul + c) mod M on both lanes, one multiplier bit per cycle, msb first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == STEP_W'(MUL_W))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mul_reg <= req.mul;
            a_a_reg <= a_a;
            a_b_reg <= a_b;
            c_a_reg <= c_a;
            c_b_reg <= c_b;
            r_a_reg <= '0;
            r_b_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == STEP_W'(MUL_W))
            begin
                r_a_reg <= mod_add(r_a_reg, c_a_reg, MOD_A);
                r_b_reg <= mod_add(r_b_reg, c_b_reg, MOD_B);
            end
            else
            begin
                r_a_reg <= mod_dbl_add(r_a_reg, a_a_reg, mul_reg[MUL_W-1], MOD_A);
                r_b_reg <= mod_dbl_add(r_b_reg, a_b_reg, mul_reg[MUL_W-1], MOD_B);
                mul_reg <= {mul_reg[MUL_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign r_a  = r_a_reg;
    assign r_b  = r_b_reg;

endmodule

FILE: rtl/two_d_pattern_count_hash_kmp.sv
// Two-dimensional pattern counter. Send the pattern first, row-major, as words
// with func = pattern; each finished row is reduced to a pair of base-26 hashes
// and the failure table over the row hashes grows by one entry. Then stream the
// grid row-major with func = grid; every word returns one result word carrying
// match_here (this character completed an occurrence), the saturating running
// total and pattern_done. func = restart clears all state but keeps the three
// size registers, which are clamped to 1..MAX. Words with a symbol below 'A',
// func 3, pattern words after the pattern is full and grid words before it is
// full change nothing but still return a result. Sequencing: hashes run through one
// shared bit-serial modular multiply-add unit; a pattern word takes one hash
// step, plus the 26^width step in the first row, plus a failure-table walk at a
// row end; a grid word takes one hash step, plus a step that removes the symbol
// leaving the window once the window is full, plus a column-state walk when a
// slice completes; each failure-link hop is a dependent read of the hash and table
// memories. After reset and every restart a clearing pass writes the per-column
// state memory with input held off; the size registers can be written meanwhile.
`include "assert_macros.svh"

module two_d_pattern_count_hash_kmp #(
    parameter int MAX_COLS         = 2048,
    parameter int MAX_PATTERN_ROWS = 2048
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tdpc_pkg::FUNC_W-1:0]         func,
    input  logic [tdpc_pkg::SYMBOL_W-1:0]       symbol,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                match_here,
    output logic [tdpc_pkg::TOTAL_W-1:0]        match_total,
    output logic                                pattern_done,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tdpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tdpc_pkg::CFG_W-1:0]          cfg_data
);
    import tdpc_pkg::*;

    localparam int PW  = $clog2(MAX_PATTERN_ROWS + 1);
    localparam int PAW = (MAX_PATTERN_ROWS > 1) ? $clog2(MAX_PATTERN_ROWS) : 1;
    localparam int CW  = $clog2(MAX_COLS + 1);
    localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam logic [CAW-1:0] CLR_LAST = CAW'(MAX_COLS - 1);

    typedef enum logic [16:0] {
        S_CLEAR  = 17'h00001,
        S_IDLE   = 17'h00002,
        S_PHASH  = 17'h00004,
        S_PPOW   = 17'h00008,
        S_PEND   = 17'h00010,
        S_PW_RD  = 17'h00020,
        S_PW_CMP = 17'h00040,
        S_PW_FIN = 17'h00080,
        S_GHASH  = 17'h00100,
        S_GSUB   = 17'h00200,
        S_GCOL   = 17'h00400,
        S_CLOAD  = 17'h00800,
        S_CW_RD  = 17'h01000,
        S_CW_CMP = 17'h02000,
        S_CFIN   = 17'h04000,
        S_GROW   = 17'h08000,
        S_RESULT = 17'h10000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]   prows_reg, prows_next;
    logic [CFG_W-1:0]   pcols_reg, pcols_next;
    logic [CFG_W-1:0]   gcols_reg, gcols_next;
    logic [HASH_W-1:0]  row_a_reg, row_a_next;
    logic [HASH_W-1:0]  row_b_reg, row_b_next;
    logic [HASH_W-1:0]  pw_a_reg, pw_a_next;
    logic [HASH_W-1:0]  pw_b_reg, pw_b_next;
    logic [PW-1:0]      prow_reg, prow_next;
    logic signed [PW:0] ptr_reg, ptr_next;
    logic signed [PW:0] walk_reg, walk_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [CAW-1:0]     kcol_reg, kcol_next;
    logic [CAW-1:0]     clr_reg, clr_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               emit_reg, emit_next;
    logic               hit_reg, hit_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_hit_reg, out_hit_next;
    logic [TOTAL_W-1:0] out_total_reg, out_total_next;
    logic               out_done_reg, out_done_next;

    // clamped sizes
    logic [PW-1:0]      hp;
    logic [CW-1:0]      wp;
    logic [CW-1:0]      wg;
    logic signed [PW:0] hp_s;
    logic signed [PW:0] hp_m1;
    logic               done_now;
    logic               sym_ok;
    logic [X_W-1:0]     x_in;
    logic [CW:0]        col_p1;
    logic signed [PW:0] walk_p1;
    logic signed [PW:0] fail_val;
    logic               row_eq;

    // shared modular unit
    mac_req_t          mac_req;
    logic [HASH_W-1:0] mac_a_a, mac_a_b, mac_c_a, mac_c_b;
    logic              mac_done;
    logic [HASH_W-1:0] mac_r_a, mac_r_b;

    // memory ports
    logic              ph_we, ph_re;
    logic [PAW-1:0]    ph_waddr, ph_raddr;
    logic [2*HASH_W-1:0] ph_wdata, ph_rdata;
    logic              fl_we, fl_re;
    logic [PW-1:0]     fl_waddr, fl_raddr;
    logic [PW:0]       fl_wdata, fl_rdata;
    logic              cs_we, cs_re;
    logic [CAW-1:0]    cs_waddr, cs_raddr;
    logic [PW-1:0]     cs_wdata, cs_rdata;
    logic              ws_we, ws_re;
    logic [CAW-1:0]    ws_waddr, ws_raddr;
    logic [X_W-1:0]    ws_wdata, ws_rdata;

    always_comb
    begin
        if (prows_reg == '0)
        begin
            hp = PW'(1);
        end
        else if (32'(prows_reg) > MAX_PATTERN_ROWS)
        begin
            hp = PW'(MAX_PATTERN_ROWS);
        end
        else
        begin
            hp = PW'(prows_reg);
        end

        if (pcols_reg == '0)
        begin
            wp = CW'(1);
        end
        else if (32'(pcols_reg) > MAX_COLS)
        begin
            wp = CW'(MAX_COLS);
        end
        else
        begin
            wp = CW'(pcols_reg);
        end

        if (gcols_reg == '0)
        begin
            wg = CW'(1);
        end
        else if (32'(gcols_reg) > MAX_COLS)
        begin
            wg = CW'(MAX_COLS);
        end
        else
        begin
            wg = CW'(gcols_reg);
        end
    end

    assign hp_s     = signed'({1'b0, hp});
    assign hp_m1    = hp_s - (PW+1)'(1);
    assign done_now = (prow_reg >= hp);
    assign sym_ok   = (symbol >= SYM_BASE);
    assign x_in     = X_W'(symbol - SYM_BASE);
    assign col_p1   = {1'b0, col_reg} + (CW+1)'(1);
    assign walk_p1  = walk_reg + (PW+1)'(1);
    // table entry zero is the -1 sentinel and never lives in memory
    assign fail_val = (walk_reg == '0) ? '1 : signed'(fl_rdata);
    assign row_eq   = (ph_rdata == {row_a_reg, row_b_reg});

    assign in_ready     = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign match_here   = out_hit_reg;
    assign match_total  = out_total_reg;
    assign pattern_done = out_done_reg;

    always_comb
    begin
        state_next     = state_reg;
        prows_next     = prows_reg;
        pcols_next     = pcols_reg;
        gcols_next     = gcols_reg;
        row_a_next     = row_a_reg;
        row_b_next     = row_b_reg;
        pw_a_next      = pw_a_reg;
        pw_b_next      = pw_b_reg;
        prow_next      = prow_reg;
        ptr_next       = ptr_reg;
        walk_next      = walk_reg;
        col_next       = col_reg;
        kcol_next      = kcol_reg;
        clr_next       = clr_reg;
        total_next     = total_reg;
        emit_next      = emit_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        out_total_next = out_total_reg;
        out_done_next  = out_done_reg;

        mac_req.start = 1'b0;
        mac_req.mul   = BASE;
        mac_a_a = row_a_reg;
        mac_a_b = row_b_reg;
        mac_c_a = HASH_W'(x_in);
        mac_c_b = HASH_W'(x_in);

        ph_we    = 1'b0;
        ph_waddr = PAW'(prow_reg);
        ph_wdata = {row_a_reg, row_b_reg};
        ph_re    = 1'b0;
        ph_raddr = PAW'(walk_reg);
        fl_we    = 1'b0;
        fl_waddr = prow_reg + PW'(1);
        fl_wdata = walk_p1;
        fl_re    = 1'b0;
        fl_raddr = PW'(walk_reg);
        cs_we    = 1'b0;
        cs_waddr = kcol_reg;
        cs_wdata = PW'(walk_p1);
        cs_re    = 1'b0;
        cs_raddr = CAW'(col_p1 - {1'b0, wp});
        ws_we    = 1'b0;
        ws_waddr = CAW'(col_reg);
        ws_wdata = x_in;
        ws_re    = 1'b0;
        ws_raddr = CAW'(col_reg - wp);

        // size registers are taken in any state
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PATTERN_ROWS: prows_next = cfg_data;
                CFG_PATTERN_COLS: pcols_next = cfg_data;
                CFG_GRID_COLS:    gcols_next = cfg_data;
                default:          ;
            endcase
        end

        // drop the result word once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                cs_we    = 1'b1;
                cs_waddr = clr_reg;
                cs_wdata = '0;
                clr_next = clr_reg + CAW'(1);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = emit_reg ? S_RESULT : S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    hit_next   = 1'b0;
                    state_next = S_RESULT;
                    case (func)
                        FUNC_RESTART:
                        begin
                            row_a_next = '0;
                            row_b_next = '0;
                            pw_a_next  = HASH_W'(1);
                            pw_b_next  = HASH_W'(1);
                            prow_next  = '0;
                            ptr_next   = '1;
                            col_next   = '0;
                            total_next = '0;
                            clr_next   = '0;
                            emit_next  = 1'b1;
                            state_next = S_CLEAR;
                        end
                        FUNC_PATTERN:
                        begin
                            if (sym_ok && !done_now)
                            begin
                                mac_req.start = 1'b1;
                                state_next    = S_PHASH;
                            end
                        end
                        FUNC_GRID:
                        begin
                            if (sym_ok && done_now)
                            begin
                                // fetch the symbol leaving the window, store the new one
                                mac_req.start = 1'b1;
                                ws_we         = 1'b1;
                                ws_re         = 1'b1;
                                state_next    = S_GHASH;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_PHASH:
            begin
                if (mac_done)
                begin
                    row_a_next = mac_r_a;
                    row_b_next = mac_r_b;
                    if (prow_reg == '0)
                    begin
                        // first row also builds 26^width
                        mac_req.start = 1'b1;
                        mac_a_a       = pw_a_reg;
                        mac_a_b       = pw_b_reg;
                        mac_c_a       = '0;
                        mac_c_b       = '0;
                        state_next    = S_PPOW;
                    end
                    else
                    begin
                        state_next = S_PEND;
                    end
                end
            end

            S_PPOW:
            begin
                if (mac_done)
                begin
                    pw_a_next  = mac_r_a;
                    pw_b_next  = mac_r_b;
                    state_next = S_PEND;
                end
            end

            S_PEND:
            begin
                if (col_p1 >= {1'b0, wp})
                begin
                    ph_we      = 1'b1;
                    walk_next  = ptr_reg;
                    state_next = S_PW_RD;
                end
                else
                begin
                    col_next   = CW'(col_p1);
                    state_next = S_RESULT;
                end
            end

            S_PW_RD:
            begin
                if (walk_reg[PW])
                begin
                    state_next = S_PW_FIN;
                end
                else
                begin
                    ph_re      = 1'b1;
                    fl_re      = 1'b1;
                    state_next = S_PW_CMP;
                end
            end

            S_PW_CMP:
            begin
                if (row_eq)
                begin
                    state_next = S_PW_FIN;
                end
                else
                begin
                    walk_next  = fail_val;
                    state_next = S_PW_RD;
                end
            end

            S_PW_FIN:
            begin
                fl_we      = 1'b1;
                ptr_next   = walk_p1;
                prow_next  = prow_reg + PW'(1);
                col_next   = '0;
                row_a_next = '0;
                row_b_next = '0;
                state_next = S_RESULT;
            end

            S_GHASH:
            begin
                if (mac_done)
                begin
                    row_a_next = mac_r_a;
                    row_b_next = mac_r_b;
                    if (col_reg >= wp)
                    begin
                        mac_req.start = 1'b1;
                        mac_req.mul   = ws_rdata;
                        mac_a_a       = pw_a_reg;
                        mac_a_b       = pw_b_reg;
                        mac_c_a       = '0;
                        mac_c_b       = '0;
                        state_next    = S_GSUB;
                    end
                    else
                    begin
                        state_next = S_GCOL;
                    end
                end
            end

            S_GSUB:
            begin
                if (mac_done)
                begin
                    row_a_next = mod_sub(row_a_reg, mac_r_a, MOD_A);
                    row_b_next = mod_sub(row_b_reg, mac_r_b, MOD_B);
                    state_next = S_GCOL;
                end
            end

            S_GCOL:
            begin
                if (col_p1 >= {1'b0, wp})
                begin
                    cs_re      = 1'b1;
                    kcol_next  = CAW'(col_p1 - {1'b0, wp});
                    state_next = S_CLOAD;
                end
                else
                begin
                    state_next = S_GROW;
                end
            end

            S_CLOAD:
            begin
                walk_next  = signed'({1'b0, cs_rdata});
                state_next = S_CW_RD;
            end

            S_CW_RD:
            begin
                if (walk_reg[PW])
                begin
                    state_next = S_CFIN;
                end
                else
                begin
                    ph_re      = 1'b1;
                    fl_re      = 1'b1;
                    state_next = S_CW_CMP;
                end
            end

            S_CW_CMP:
            begin
                if ((walk_reg >= hp_s) || !row_eq)
                begin
                    walk_next  = fail_val;
                    state_next = S_CW_RD;
                end
                else
                begin
                    state_next = S_CFIN;
                end
            end

            S_CFIN:
            begin
                cs_we    = 1'b1;
                hit_next = (walk_reg == hp_m1);
                if ((walk_reg == hp_m1) && (total_reg < TOTAL_MAX))
                begin
                    total_next = total_reg + TOTAL_W'(1);
                end
                state_next = S_GROW;
            end

            S_GROW:
            begin
                if (col_p1 >= {1'b0, wg})
                begin
                    col_next   = '0;
                    row_a_next = '0;
                    row_b_next = '0;
                end
                else
                begin
                    col_next = CW'(col_p1);
                end
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = hit_reg;
                    out_total_next = total_reg;
                    out_done_next  = done_now;
                    emit_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            prows_reg     <= CFG_W'(1);
            pcols_reg     <= CFG_W'(1);
            gcols_reg     <= CFG_W'(1);
            row_a_reg     <= '0;
            row_b_reg     <= '0;
            pw_a_reg      <= HASH_W'(1);
            pw_b_reg      <= HASH_W'(1);
            prow_reg      <= '0;
            ptr_reg       <= '1;
            col_reg       <= '0;
            clr_reg       <= '0;
            total_reg     <= '0;
            emit_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prows_reg     <= prows_next;
            pcols_reg     <= pcols_next;
            gcols_reg     <= gcols_next;
            row_a_reg     <= row_a_next;
            row_b_reg     <= row_b_next;
            pw_a_reg      <= pw_a_next;
            pw_b_reg      <= pw_b_next;
            prow_reg      <= prow_next;
            ptr_reg       <= ptr_next;
            col_reg       <= col_next;
            clr_reg       <= clr_next;
            total_reg     <= total_next;
            emit_reg      <= emit_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_reg      <= walk_next;
        kcol_reg      <= kcol_next;
        out_hit_reg   <= out_hit_next;
        out_total_reg <= out_total_next;
        out_done_reg  <= out_done_next;
    end

    tdpc_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mac_req),
        .a_a   (mac_a_a),
        .a_b   (mac_a_b),
        .c_a   (mac_c_a),
        .c_b   (mac_c_b),
        .done  (mac_done),
        .r_a   (mac_r_a),
        .r_b   (mac_r_b)
    );

    // pattern row hashes, lane a in the upper half
    tdpc_ram #(.WIDTH(2 * HASH_W), .DEPTH(MAX_PATTERN_ROWS)) u_phash (
        .clk   (clk),
        .we    (ph_we),
        .waddr (ph_waddr),
        .wdata (ph_wdata),
        .re    (ph_re),
        .raddr (ph_raddr),
        .rdata (ph_rdata)
    );

    tdpc_ram #(.WIDTH(PW + 1), .DEPTH(MAX_PATTERN_ROWS + 1)) u_fail (
        .clk   (clk),
        .we    (fl_we),
        .waddr (fl_waddr),
        .wdata (fl_wdata),
        .re    (fl_re),
        .raddr (fl_raddr),
        .rdata (fl_rdata)
    );

    // matched-row count for each slice start column
    tdpc_ram #(.WIDTH(PW), .DEPTH(MAX_COLS)) u_colst (
        .clk   (clk),
        .we    (cs_we),
        .waddr (cs_waddr),
        .wdata (cs_wdata),
        .re    (cs_re),
        .raddr (cs_raddr),
        .rdata (cs_rdata)
    );

    tdpc_ram #(.WIDTH(X_W), .DEPTH(MAX_COLS)) u_winsym (
        .clk   (clk),
        .we    (ws_we),
        .waddr (ws_waddr),
        .wdata (ws_wdata),
        .re    (ws_re),
        .raddr (ws_raddr),
        .rdata (ws_rdata)
    );

    `ASSERT_SAME(a_hit_needs_pattern, out_valid && match_here, pattern_done, "match reported before pattern complete")
    `ASSERT_NEXT(a_restart_clears, in_valid && in_ready && (func == FUNC_RESTART), (state_reg == S_CLEAR) && (total_reg == '0), "restart did not clear")
    `ASSERT_NEXT(a_count_step, (state_reg == S_CFIN) && (walk_reg == hp_m1) && (total_reg < TOTAL_MAX), total_reg == $past(total_reg) + TOTAL_W'(1), "hit not counted")

endmodule

FILE: dv/tb_two_d_pattern_count_hash_kmp.sv
`timescale 1ns / 100ps

module tb_two_d_pattern_count_hash_kmp;
    import tdpc_pkg::*;

    // func code 3 is unused by the block and must be ignored
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int  COLS_MAX = 2048;
    localparam int  ROWS_MAX = 2048;
    localparam longint HA = 64'd1000000007;
    localparam longint HB = 64'd1000000009;
    localparam int  SETTLE = 400;

    typedef struct {
        logic                hit;
        logic [TOTAL_W-1:0]  total;
        logic                done;
    } occurrence_t;

    // Mirror of the block: row hashes, failure table, per-column KMP states.
    class occurrence_board;
        int unsigned rows_reg, cols_reg, grid_reg;
        longint pat_a[ROWS_MAX];
        longint pat_b[ROWS_MAX];
        int     fail_link[ROWS_MAX + 1];
        int     col_state[COLS_MAX];
        int     window[COLS_MAX];
        longint hash_a, hash_b, pow_a, pow_b;
        int     row_idx, prefix, col_idx;
        int     total;
        occurrence_t expected_q[$];
        int     errors;

        function new();
            rows_reg = 1;
            cols_reg = 1;
            grid_reg = 1;
            errors = 0;
            clear();
        endfunction

        function void clear();
            for (int i = 0; i < ROWS_MAX; i++)
            begin
                pat_a[i] = 0;
                pat_b[i] = 0;
                fail_link[i] = 0;
            end
            fail_link[ROWS_MAX] = 0;
            fail_link[0] = -1;
            for (int i = 0; i < COLS_MAX; i++)
            begin
                col_state[i] = 0;
                window[i] = 0;
            end
            hash_a = 0;
            hash_b = 0;
            pow_a = 1;
            pow_b = 1;
            row_idx = 0;
            prefix = -1;
            col_idx = 0;
            total = 0;
        endfunction

        function int unsigned clamp_size(int unsigned v, int unsigned hi);
            if (v < 1)
            begin
                return 1;
            end
            if (v > hi)
            begin
                return hi;
            end
            return v;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_PATTERN_ROWS: rows_reg = val;
                CFG_PATTERN_COLS: cols_reg = val;
                CFG_GRID_COLS:    grid_reg = val;
                default: ;
            endcase
        endfunction

        function int height();
            return clamp_size(rows_reg, ROWS_MAX);
        endfunction

        function bit loaded();
            return row_idx >= height();
        endfunction

        // Advance the model by one accepted word and queue its result.
        function void note_word(logic [FUNC_W-1:0] f, logic [SYMBOL_W-1:0] s);
            int hp, wp, wg, c, j, it;
            longint x, o;
            bit done, hit;
            occurrence_t e;
            hp = clamp_size(rows_reg, ROWS_MAX);
            wp = clamp_size(cols_reg, COLS_MAX);
            wg = clamp_size(grid_reg, COLS_MAX);
            done = row_idx >= hp;
            hit = 0;
            if (f == FUNC_RESTART)
            begin
                clear();
            end
            else if ((f == FUNC_PATTERN || f == FUNC_GRID) && s >= SYM_BASE)
            begin
                x = s - SYM_BASE;
                c = col_idx;
                if (f == FUNC_PATTERN && !done)
                begin
                    hash_a = (hash_a * 26 + x) % HA;
                    hash_b = (hash_b * 26 + x) % HB;
                    if (row_idx == 0)
                    begin
                        pow_a = (pow_a * 26) % HA;
                        pow_b = (pow_b * 26) % HB;
                    end
                    if (c + 1 >= wp)
                    begin
                        // close the row and extend the failure table
                        if (row_idx < ROWS_MAX)
                        begin
                            pat_a[row_idx] = hash_a;
                            pat_b[row_idx] = hash_b;
                            j = prefix;
                            while (j >= 0 && !(pat_a[row_idx] == pat_a[j] &&
                                               pat_b[row_idx] == pat_b[j]))
                                j = fail_link[j];
                            j++;
                            fail_link[row_idx + 1] = j;
                            prefix = j;
                            row_idx++;
                        end
                        col_idx = 0;
                        hash_a = 0;
                        hash_b = 0;
                    end
                    else
                    begin
                        col_idx = c + 1;
                    end
                end
                else if (f == FUNC_GRID && done)
                begin
                    window[c] = int'(x);
                    hash_a = (hash_a * 26 + x) % HA;
                    hash_b = (hash_b * 26 + x) % HB;
                    if (c >= wp)
                    begin
                        o = window[c - wp];
                        hash_a = (hash_a + HA - (o * pow_a) % HA) % HA;
                        hash_b = (hash_b + HB - (o * pow_b) % HB) % HB;
                    end
                    if (c + 1 >= wp)
                    begin
                        it = col_state[c + 1 - wp];
                        while (it >= hp || (it >= 0 && (pat_a[it] != hash_a ||
                                                        pat_b[it] != hash_b)))
                            it = fail_link[it];
                        hit = (it == hp - 1);
                        col_state[c + 1 - wp] = it + 1;
                        if (hit && total < TOTAL_MAX)
                        begin
                            total++;
                        end
                    end
                    if (c + 1 >= wg)
                    begin
                        col_idx = 0;
                        hash_a = 0;
                        hash_b = 0;
                    end
                    else
                    begin
                        col_idx = c + 1;
                    end
                end
            end
            e.hit = hit;
            e.total = TOTAL_W'(total);
            e.done = row_idx >= hp;
            expected_q.push_back(e);
        endfunction

        function void check_word(logic mh, logic [TOTAL_W-1:0] mt, logic pd);
            occurrence_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("%0t: result word with nothing outstanding: %0b %0d %0b",
                             $realtime, mh, mt, pd);
                end
                return;
            end
            e = expected_q.pop_front();
            if (mh !== e.hit || mt !== e.total || pd !== e.done)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("%0t: match_here exp %0b got %0b, total exp %0d got %0d, done exp %0b got %0b",
                             $realtime, e.hit, mh, e.total, mt, e.done, pd);
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [FUNC_W-1:0]    func;
    logic [SYMBOL_W-1:0]  symbol;
    logic                 out_valid;
    logic                 out_ready;
    logic                 match_here;
    logic [TOTAL_W-1:0]   match_total;
    logic                 pattern_done;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    occurrence_board board = new();
    int words_sent = 0;
    int burst_left = 0;
    int stall_cyc = 0;
    int stall_mode = 0;

    two_d_pattern_count_hash_kmp i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .symbol       (symbol),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .match_here   (match_here),
        .match_total  (match_total),
        .pattern_done (pattern_done),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Receiver stall pattern: switch among free-running, coin-flip,
    // one-in-four and a long stall.
    always @(negedge clk)
    begin
        if (stall_cyc % 64 == 0)
        begin
            stall_mode = $urandom_range(0, 3);
        end
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= (stall_cyc % 4 == 0);
            default: out_ready <= (stall_cyc % 64 >= 40);
        endcase
        stall_cyc++;
    end

    // Check every result word taken by the receiver.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            board.check_word(match_here, match_total, pattern_done);
        end
    end

    // Send one input word; idle between bursts of random length.
    task automatic send_word(logic [FUNC_W-1:0] f, logic [SYMBOL_W-1:0] s);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid = 1'b0;
                gap = $urandom_range(1, 6);
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_valid = 1'b1;
        func = f;
        symbol = s;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_word(f, s);
        words_sent++;
    endtask

    // Drop valid and wait until every result word has come back.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_reg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Pick a letter: narrow alphabets make occurrences frequent.
    function automatic logic [SYMBOL_W-1:0] pick_letter(bit narrow);
        if (narrow)
        begin
            return SYM_BASE + SYMBOL_W'($urandom_range(0, 1));
        end
        return SYMBOL_W'($urandom_range(65, 127));
    endfunction

    // Feed one word of the given kind, with occasional noise.
    task automatic feed(logic [FUNC_W-1:0] f, bit narrow);
        case ($urandom_range(0, 15))
            0: send_word(FUNC_UNUSED, pick_letter(narrow));
            1: send_word(f, SYMBOL_W'($urandom_range(0, 64)));
            2: send_word((f == FUNC_GRID) ? FUNC_PATTERN : FUNC_GRID, pick_letter(narrow));
            default: send_word(f, pick_letter(narrow));
        endcase
    endtask

    initial
    begin
        int phase;
        int old_hp;
        int n;
        bit narrow;
        logic [CFG_W-1:0] v;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FUNC_PATTERN;
        symbol = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PATTERN_ROWS;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: 2x2 pattern AB/BA over a 4-wide grid.
        write_reg(CFG_PATTERN_ROWS, 12'd2);
        write_reg(CFG_PATTERN_COLS, 12'd2);
        write_reg(CFG_GRID_COLS, 12'd4);
        send_word(FUNC_GRID, SYMBOL_W'("A"));    // grid before pattern: ignored
        send_word(FUNC_PATTERN, 7'd64);     // below 'A': ignored
        send_word(FUNC_PATTERN, 7'd0);
        send_word(FUNC_UNUSED, SYMBOL_W'("A"));
        send_word(FUNC_PATTERN, SYMBOL_W'("A"));
        send_word(FUNC_PATTERN, SYMBOL_W'("B"));
        send_word(FUNC_PATTERN, SYMBOL_W'("B"));
        send_word(FUNC_PATTERN, SYMBOL_W'("A"));
        send_word(FUNC_PATTERN, 7'd127);    // pattern already full: ignored
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 4; c++)
                send_word(FUNC_GRID, ((r + c) % 2 == 0) ? SYMBOL_W'("A") : SYMBOL_W'("B"));
        send_word(FUNC_GRID, 7'd122);
        send_word(FUNC_RESTART, 7'd127);

        // Random phases: configuration, optional restart, pattern, grid.
        phase = 0;
        while (words_sent < 430)
        begin
            drain();
            old_hp = board.height();
            case (phase)
                0: write_reg(CFG_PATTERN_ROWS, 12'd4095);
                1:
                begin
                    write_reg(CFG_PATTERN_ROWS, 12'd1);
                    write_reg(CFG_PATTERN_COLS, 12'd4095);
                end
                2:
                begin
                    write_reg(CFG_PATTERN_COLS, 12'd2);
                    write_reg(CFG_GRID_COLS, 12'd4095);
                end
                3:
                begin
                    write_reg(CFG_PATTERN_ROWS, 12'd0);
                    write_reg(CFG_PATTERN_COLS, 12'd0);
                    write_reg(CFG_GRID_COLS, 12'd0);
                end
                default:
                begin
                    if ($urandom_range(0, 1))
                    begin
                        v = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom) :
                                                          CFG_W'($urandom_range(1, 3));
                        write_reg(CFG_PATTERN_ROWS, v);
                    end
                    if ($urandom_range(0, 1))
                    begin
                        v = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom) :
                                                          CFG_W'($urandom_range(1, 4));
                        write_reg(CFG_PATTERN_COLS, v);
                    end
                    if ($urandom_range(0, 1))
                    begin
                        v = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom) :
                                                          CFG_W'($urandom_range(1, 8));
                        write_reg(CFG_GRID_COLS, v);
                    end
                end
            endcase
            phase++;
            // a taller pattern, or a shorter one cut mid-row, needs fresh state
            // so no unwritten entry is read
            if (board.height() > old_hp ||
                (board.height() < old_hp && board.col_idx != 0) ||
                $urandom_range(0, 3) != 0)
            begin
                send_word(FUNC_RESTART, SYMBOL_W'($urandom));
            end
            narrow = $urandom_range(0, 3) != 0;
            if (!board.loaded())
            begin
                n = board.height() * board.clamp_size(board.cols_reg, COLS_MAX);
                if (n > 40)
                begin
                    n = 40;
                end
                repeat (n) feed(FUNC_PATTERN, narrow);
            end
            n = board.clamp_size(board.grid_reg, COLS_MAX) *
                $urandom_range(board.height(), board.height() + 3);
            if (n > 120)
            begin
                n = 120;
            end
            repeat (n) feed(FUNC_GRID, narrow);
        end

        drain();
        if (board.errors == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
